// ===== src/ogrm_pkg.sv =====
// Shared types and constants for the occupancy grid rectangle marker.
package ogrm_pkg;

	localparam int COORD_W  = 4;
	localparam int EXTENT_W = 4;
	// Widths and heights above this are saturated.
	localparam logic [EXTENT_W-1:0] MAX_EXTENT = 4'd8;

	typedef struct packed {
		logic [COORD_W-1:0]  origin_x;
		logic [COORD_W-1:0]  origin_y;
		logic [EXTENT_W-1:0] rect_width;
		logic [EXTENT_W-1:0] rect_height;
	} rect_cmd_t;

	typedef struct packed {
		logic [COORD_W-1:0] cell_x;
		logic [COORD_W-1:0] cell_y;
		logic               last_cell;
	} cell_result_t;

endpackage

// ===== src/occupancy_grid_rect_marker_unit.sv =====
// Top level: rectangle scan sequencer over the occupancy map.
//
// Usage: drive cmd and pulse start while busy is low; the beat is taken at
// that edge. The block then scans the rectangle column by column, rows
// bottom to top, one cell per cycle through the single map read port,
// with the check of one cell overlapped with the read of the next.
// Each newly occupied cell comes out on result for exactly one cycle with
// result_strobe high; the last new cell of a rectangle has last_cell set.
// One result is held back in a pending register so the last flag is known
// when it leaves.
// Timing: busy stays high from the accept edge until the rectangle is done.
// The extents W and H are saturated to 8; an empty rectangle skips the scan.
// A result leaves once the next new cell has been checked; the final one
// appears in the first cycle busy is low again.
// Reset: the map is cleared by a pass over all GRID_COLS * GRID_ROWS cells
// (256 at the defaults), during which busy is high.
// The receiver cannot stall: every strobed result is taken.
module occupancy_grid_rect_marker_unit #(
	parameter int GRID_COLS = 16,
	parameter int GRID_ROWS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  ogrm_pkg::rect_cmd_t     cmd,
	output ogrm_pkg::cell_result_t  result,
	output logic                    result_strobe
);
	import ogrm_pkg::*;

	localparam int DEPTH = GRID_COLS * GRID_ROWS;
	localparam int AW    = $clog2(DEPTH);
	localparam int SUM_W = COORD_W + 1;

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DRAIN, ST_FIN} state_t;

	state_t              state_q;
	logic [COORD_W-1:0]  ox_q, oy_q;
	logic [EXTENT_W-1:0] w_q, h_q, m_q, n_q;
	logic                valid_s1, in_grid_s1;
	logic [COORD_W-1:0]  x_s1, y_s1;
	logic [AW-1:0]       addr_s1;
	logic                pend_q;
	logic [COORD_W-1:0]  pend_x_q, pend_y_q;
	cell_result_t        result_q;
	logic                strobe_q;

	logic [EXTENT_W-1:0] w_sat, h_sat;
	logic [SUM_W-1:0]    x_c, y_c;
	logic                in_grid_c, n_wrap, m_last, new_cell;
	logic [AW-1:0]       rd_addr;
	logic                rd_data, map_ready;

	assign w_sat = (cmd.rect_width  > MAX_EXTENT) ? MAX_EXTENT : cmd.rect_width;
	assign h_sat = (cmd.rect_height > MAX_EXTENT) ? MAX_EXTENT : cmd.rect_height;

	assign x_c       = SUM_W'(ox_q) + SUM_W'(m_q);
	assign y_c       = SUM_W'(oy_q) + SUM_W'(n_q);
	assign in_grid_c = (32'(x_c) < GRID_COLS) && (32'(y_c) < GRID_ROWS);
	assign rd_addr   = AW'(32'(x_c) * GRID_ROWS + 32'(y_c));
	assign n_wrap    = (n_q + 1'b1) == h_q;
	assign m_last    = (m_q + 1'b1) == w_q;
	assign new_cell  = valid_s1 && in_grid_s1 && !rd_data;

	ogrm_map #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_map (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.wr_en  (new_cell),
		.wr_addr(addr_s1),
		.ready  (map_ready)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			ox_q       <= '0;
			oy_q       <= '0;
			w_q        <= '0;
			h_q        <= '0;
			m_q        <= '0;
			n_q        <= '0;
			valid_s1   <= 1'b0;
			in_grid_s1 <= 1'b0;
			x_s1       <= '0;
			y_s1       <= '0;
			addr_s1    <= '0;
			pend_q     <= 1'b0;
			pend_x_q   <= '0;
			pend_y_q   <= '0;
			result_q   <= '0;
			strobe_q   <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			valid_s1 <= 1'b0;

			// A new cell pushes out the previous pending one, not last.
			if (new_cell) begin
				pend_q   <= 1'b1;
				pend_x_q <= x_s1;
				pend_y_q <= y_s1;
				if (pend_q) begin
					result_q <= '{cell_x: pend_x_q, cell_y: pend_y_q, last_cell: 1'b0};
					strobe_q <= 1'b1;
				end
			end

			case (state_q)
				ST_IDLE: begin
					if (start && map_ready) begin
						ox_q <= cmd.origin_x;
						oy_q <= cmd.origin_y;
						w_q  <= w_sat;
						h_q  <= h_sat;
						m_q  <= '0;
						n_q  <= '0;
						state_q <= (w_sat == '0 || h_sat == '0) ? ST_FIN : ST_SCAN;
					end
				end
				ST_SCAN: begin
					valid_s1   <= 1'b1;
					in_grid_s1 <= in_grid_c;
					x_s1       <= x_c[COORD_W-1:0];
					y_s1       <= y_c[COORD_W-1:0];
					addr_s1    <= rd_addr;
					if (n_wrap) begin
						n_q <= '0;
						m_q <= m_q + 1'b1;
						if (m_last) begin
							state_q <= ST_DRAIN;
						end
					end else begin
						n_q <= n_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (pend_q) begin
						result_q <= '{cell_x: pend_x_q, cell_y: pend_y_q, last_cell: 1'b1};
						strobe_q <= 1'b1;
						pend_q   <= 1'b0;
					end
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy          = (state_q != ST_IDLE) || !map_ready;
	assign result        = result_q;
	assign result_strobe = strobe_q;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted beat did not raise busy");

	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !pend_q)
		else $error("pending cell left behind after rectangle finished");

	a_s1_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (state_q == ST_SCAN || state_q == ST_DRAIN))
		else $error("check stage active outside scan");

	a_no_out_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		!map_ready |-> (!result_strobe && state_q == ST_IDLE))
		else $error("activity during map clear");

endmodule

// ===== src/ogrm_map.sv =====
// One-bit occupancy map memory with a clearing pass after reset.
module ogrm_map #(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [AW-1:0] rd_addr,
	output logic          rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	output logic          ready
);
	import ogrm_pkg::*;

	logic          mem [DEPTH];
	logic [AW-1:0] clr_addr_q;
	logic          clearing_q;
	logic          rd_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			clearing_q <= 1'b1;
		end else if (clearing_q) begin
			if (clr_addr_q == AW'(DEPTH - 1)) begin
				clearing_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	// Clear pass owns the write port until every cell reads free.
	always_ff @(posedge clk) begin
		if (clearing_q) begin
			mem[clr_addr_q] <= 1'b0;
		end else if (wr_en) begin
			mem[wr_addr] <= 1'b1;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;
	assign ready   = !clearing_q;

endmodule
